// ===== rtl/ats_pkg.sv =====
// Shared types and constants for the ATA task-file sequencer.
package ats_pkg;

  // Request word taken on the input channel
  typedef struct packed {
    logic        direction;
    logic [1:0]  device_slot;
    logic [47:0] block_address;
    logic [7:0]  sector_count;
  } req_t;

  // Register write word given on the output channel
  typedef struct packed {
    logic       channel;
    logic [3:0] register_index;
    logic [7:0] write_data;
    logic       last;
  } res_t;

  // Per-slot configuration bits
  typedef struct packed {
    logic [3:0] slot_channel_bits;
    logic [3:0] slot_slave_bits;
    logic [3:0] lba28_capable_bits;
  } cfg_t;

  typedef enum logic [1:0] {
    CFG_CHANNEL = 2'd0,
    CFG_SLAVE   = 2'd1,
    CFG_LBA28   = 2'd2
  } cfg_index_e;

  localparam logic [3:0] CFG_CHANNEL_RESET = 4'd12;
  localparam logic [3:0] CFG_SLAVE_RESET   = 4'd10;
  localparam logic [3:0] CFG_LBA28_RESET   = 4'd0;

  // Classified request, ready to be sequenced
  typedef struct packed {
    logic            channel;
    logic            lba48;
    logic [7:0]      devsel;
    logic [7:0]      count;
    logic [7:0]      command;
    logic [5:0][7:0] addr_bytes;
  } job_t;

  // Task-file register indexes
  localparam logic [3:0] REG_COUNT0  = 4'h2;
  localparam logic [3:0] REG_LBA0    = 4'h3;
  localparam logic [3:0] REG_LBA1    = 4'h4;
  localparam logic [3:0] REG_LBA2    = 4'h5;
  localparam logic [3:0] REG_DEVSEL  = 4'h6;
  localparam logic [3:0] REG_COMMAND = 4'h7;
  localparam logic [3:0] REG_COUNT1  = 4'h8;
  localparam logic [3:0] REG_LBA3    = 4'h9;
  localparam logic [3:0] REG_LBA4    = 4'hA;
  localparam logic [3:0] REG_LBA5    = 4'hB;
  localparam logic [3:0] REG_CONTROL = 4'hC;

  localparam logic [7:0] CTRL_BASE     = 8'h02;
  localparam logic [7:0] CTRL_HOB      = 8'h80;
  localparam logic [7:0] DEVSEL_CHS    = 8'hA0;
  localparam logic [7:0] DEVSEL_LBA    = 8'hE0;
  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_WRITE     = 8'h30;
  localparam logic [7:0] CMD_READ_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

  // CHS conversion: divide the 28-bit address by 63 through a reciprocal
  localparam int          LBA28_W     = 28;
  localparam int          RECIP_W     = 29;
  localparam int          RECIP_SHIFT = 34;
  localparam int          PROD_W      = LBA28_W + RECIP_W;
  localparam int          TRACK_W     = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_63 = 29'd272696336;
  localparam logic [6:0]  SECTORS_PER_TRACK = 7'd63;

  // Output sequence
  localparam int STEP_W = 5;
  typedef enum logic [3:0] {
    OP_CTRL     = 4'd0,
    OP_CTRL_HOB = 4'd1,
    OP_DEVSEL   = 4'd2,
    OP_COUNT1   = 4'd3,
    OP_LBA3     = 4'd4,
    OP_LBA4     = 4'd5,
    OP_LBA5     = 4'd6,
    OP_COUNT0   = 4'd7,
    OP_LBA0     = 4'd8,
    OP_LBA1     = 4'd9,
    OP_LBA2     = 4'd10,
    OP_COMMAND  = 4'd11
  } op_e;

  // Queue between classifier and sequencer
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_DEPTH = 2 ** QUEUE_PTR_W;

endpackage

// ===== rtl/ats_front.sv =====
// Request intake and address-mode classification.
module ats_front import ats_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic job_valid,
  input  logic job_ready,
  output job_t job_data
);

  logic              s1_valid;
  req_t              s1_req;
  logic [PROD_W-1:0] prod;

  logic                   lba48;
  logic                   lba28;
  logic                   slave;
  logic [TRACK_W-1:0]     track0;
  logic [TRACK_W-1:0]     track;
  logic [6:0]             rem0;
  logic [6:0]             sect_r;
  logic                   fix;
  logic [15:0]            cyl;
  logic [3:0]             head;
  logic [7:0]             devsel_base;

  assign in_ready = !s1_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Reciprocal product for the divide by 63
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req <= in_data;
      prod   <= PROD_W'(in_data.block_address[LBA28_W-1:0]) * PROD_W'(RECIP_63);
    end
  end

  always_comb begin
    lba48  = |s1_req.block_address[47:LBA28_W];
    lba28  = cfg.lba28_capable_bits[s1_req.device_slot];
    slave  = cfg.slot_slave_bits[s1_req.device_slot];
    track0 = prod[PROD_W-1:RECIP_SHIFT];
    // low 7 bits of address - 63*track0; true value is below 126
    rem0   = s1_req.block_address[6:0] - {track0[0], 6'b0} + track0[6:0];
    fix    = (rem0 >= SECTORS_PER_TRACK);
    track  = track0 + TRACK_W'(fix);
    sect_r = fix ? (rem0 - SECTORS_PER_TRACK) : rem0;
    cyl    = track[19:4];

    if (lba48) begin
      head = 4'd0;
    end else if (lba28) begin
      head = s1_req.block_address[27:24];
    end else begin
      head = track[3:0];
    end
    devsel_base = (lba48 || lba28) ? DEVSEL_LBA : DEVSEL_CHS;

    job_data.channel = cfg.slot_channel_bits[s1_req.device_slot];
    job_data.lba48   = lba48;
    job_data.devsel  = devsel_base | {3'b000, slave, head};
    job_data.count   = s1_req.sector_count;
    if (lba48) begin
      job_data.command = s1_req.direction ? CMD_WRITE_EXT : CMD_READ_EXT;
    end else begin
      job_data.command = s1_req.direction ? CMD_WRITE : CMD_READ;
    end

    if (lba48 || lba28) begin
      job_data.addr_bytes = s1_req.block_address;
    end else begin
      job_data.addr_bytes = {24'b0, cyl[15:8], cyl[7:0], {1'b0, sect_r} + 8'd1};
    end
  end

  assign job_valid = s1_valid;

endmodule

// ===== rtl/ats_queue.sv =====
// Two-entry queue of classified requests.
module ats_queue import ats_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   fill;
  logic                   push;
  logic                   pop;

  assign push_ready = (fill != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/ats_back.sv =====
// Register-write sequencer with output register.
module ats_back import ats_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic [STEP_W-1:0] step;
  logic              load;
  op_e               op;
  res_t              word;

  function automatic op_e op_for(input logic lba48, input logic [STEP_W-1:0] s);
    op_e o;
    if (!lba48) begin
      case (s)
        5'd0:    o = OP_CTRL;
        5'd1:    o = OP_DEVSEL;
        5'd2:    o = OP_COUNT0;
        5'd3:    o = OP_LBA0;
        5'd4:    o = OP_LBA1;
        5'd5:    o = OP_LBA2;
        default: o = OP_COMMAND;
      endcase
    end else begin
      case (s)
        5'd0:    o = OP_CTRL;
        5'd1:    o = OP_DEVSEL;
        5'd2:    o = OP_CTRL_HOB;
        5'd3:    o = OP_COUNT1;
        5'd4:    o = OP_CTRL;
        5'd5:    o = OP_CTRL_HOB;
        5'd6:    o = OP_LBA3;
        5'd7:    o = OP_CTRL;
        5'd8:    o = OP_CTRL_HOB;
        5'd9:    o = OP_LBA4;
        5'd10:   o = OP_CTRL;
        5'd11:   o = OP_CTRL_HOB;
        5'd12:   o = OP_LBA5;
        5'd13:   o = OP_CTRL;
        5'd14:   o = OP_COUNT0;
        5'd15:   o = OP_LBA0;
        5'd16:   o = OP_LBA1;
        5'd17:   o = OP_LBA2;
        default: o = OP_COMMAND;
      endcase
    end
    return o;
  endfunction

  assign load      = job_valid && (!out_valid || out_ready);
  assign op        = op_for(job_data.lba48, step);
  // drop the job once its command word is loaded
  assign job_ready = load && (op == OP_COMMAND);

  always_comb begin
    word.channel = job_data.channel;
    word.last    = 1'b0;
    case (op)
      OP_CTRL: begin
        word.register_index = REG_CONTROL;
        word.write_data     = CTRL_BASE;
      end
      OP_CTRL_HOB: begin
        word.register_index = REG_CONTROL;
        word.write_data     = CTRL_HOB | CTRL_BASE;
      end
      OP_DEVSEL: begin
        word.register_index = REG_DEVSEL;
        word.write_data     = job_data.devsel;
      end
      OP_COUNT1: begin
        word.register_index = REG_COUNT1;
        word.write_data     = 8'h00;
      end
      OP_LBA3: begin
        word.register_index = REG_LBA3;
        word.write_data     = job_data.addr_bytes[3];
      end
      OP_LBA4: begin
        word.register_index = REG_LBA4;
        word.write_data     = job_data.addr_bytes[4];
      end
      OP_LBA5: begin
        word.register_index = REG_LBA5;
        word.write_data     = job_data.addr_bytes[5];
      end
      OP_COUNT0: begin
        word.register_index = REG_COUNT0;
        word.write_data     = job_data.count;
      end
      OP_LBA0: begin
        word.register_index = REG_LBA0;
        word.write_data     = job_data.addr_bytes[0];
      end
      OP_LBA1: begin
        word.register_index = REG_LBA1;
        word.write_data     = job_data.addr_bytes[1];
      end
      OP_LBA2: begin
        word.register_index = REG_LBA2;
        word.write_data     = job_data.addr_bytes[2];
      end
      default: begin
        word.register_index = REG_COMMAND;
        word.write_data     = job_data.command;
        word.last           = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= (op == OP_COMMAND) ? '0 : step + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= word;
    end
  end

endmodule

// ===== rtl/ata_taskfile_sequencer_unit.sv =====
// The first register write word passes the intake register, the queue and the output register before it is valid.
// Throughput: one word per cycle while out_ready is high; a request gives 7 words in CHS and
// LBA28 mode and 19 in LBA48 mode, all through the single output register of the sequencer.
// Up to three requests are held (intake stage plus two-entry queue) while words drain.
// Reset clears all control state and loads the slot registers with their defaults.
module ata_taskfile_sequencer_unit import ats_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_data,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [3:0] wr_data
);

  cfg_t cfg;
  logic f_valid;
  logic f_ready;
  job_t f_data;
  logic q_valid;
  logic q_ready;
  job_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_channel_bits  <= CFG_CHANNEL_RESET;
      cfg.slot_slave_bits    <= CFG_SLAVE_RESET;
      cfg.lba28_capable_bits <= CFG_LBA28_RESET;
    end else if (wr_en) begin
      case (cfg_index_e'(wr_index))
        CFG_CHANNEL: cfg.slot_channel_bits  <= wr_data;
        CFG_SLAVE:   cfg.slot_slave_bits    <= wr_data;
        CFG_LBA28:   cfg.lba28_capable_bits <= wr_data;
        default:     cfg <= cfg;
      endcase
    end
  end

  ats_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_data  (f_data)
  );

  ats_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  ats_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job_data  (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_pop_loads_last: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> (out_valid && out_data.last))
    else $error("queue entry dropped without a final command word");

  a_last_is_command: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last) |-> (out_data.register_index == REG_COMMAND))
    else $error("last marker on a non-command write");

  a_control_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.register_index == REG_CONTROL) |->
      (out_data.write_data == CTRL_BASE || out_data.write_data == (CTRL_HOB | CTRL_BASE)))
    else $error("unexpected control register data");
`endif

endmodule

// ===== verif/ata_taskfile_sequencer_unit_tb.sv =====
// Self-checking testbench for the ATA task-file sequencer: directed and random requests.
module ata_taskfile_sequencer_unit_tb;
  import ats_pkg::*;

  localparam int         WATCHDOG_LIMIT = 4000;
  localparam logic [1:0] CFG_SPARE      = 2'd3;
  localparam logic [47:0] LBA48_START   = 48'h1000_0000;
  localparam logic [47:0] CHS_SECTORS   = 48'd63;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  req_t       in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  res_t       out_data;
  logic       wr_en = 1'b0;
  logic [1:0] wr_index = '0;
  logic [3:0] wr_data = '0;

  // Own copy of the slot registers
  logic [3:0] chan_map  = CFG_CHANNEL_RESET;
  logic [3:0] slave_map = CFG_SLAVE_RESET;
  logic [3:0] lba_map   = CFG_LBA28_RESET;

  res_t pending_writes[$];
  int   mismatch_count = 0;
  int   idle_cycles = 0;
  bit   quiet = 1'b0;

  ata_taskfile_sequencer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_write(input logic ch, input logic [3:0] idx,
                                     input logic [7:0] data, input logic lst);
    res_t w;
    w.channel        = ch;
    w.register_index = idx;
    w.write_data     = data;
    w.last           = lst;
    pending_writes.push_back(w);
  endfunction

  // High-order register write, preceded by a HOB control write and followed by a plain control write
  function automatic void push_high_write(input logic ch, input logic [3:0] idx,
                                          input logic [7:0] data);
    push_write(ch, REG_CONTROL, CTRL_HOB | CTRL_BASE, 1'b0);
    push_write(ch, idx, data, 1'b0);
    push_write(ch, REG_CONTROL, CTRL_BASE, 1'b0);
  endfunction

  function automatic void predict_taskfile_writes(input req_t r);
    logic            ch, slave, ext;
    logic [47:0]     addr, track;
    logic [15:0]     cyl;
    logic [3:0]      head;
    logic [5:0][7:0] bytes;
    logic [7:0]      sel, cmd;
    ch    = chan_map[r.device_slot];
    slave = slave_map[r.device_slot];
    addr  = r.block_address;
    ext   = (addr >= LBA48_START);
    if (ext) begin
      bytes = addr;
      head  = 4'h0;
      sel   = DEVSEL_LBA;
      cmd   = r.direction ? CMD_WRITE_EXT : CMD_READ_EXT;
    end else if (lba_map[r.device_slot]) begin
      bytes = {24'h0, addr[23:0]};
      head  = addr[27:24];
      sel   = DEVSEL_LBA;
      cmd   = r.direction ? CMD_WRITE : CMD_READ;
    end else begin
      track    = addr / CHS_SECTORS;
      cyl      = 16'(track >> 4);
      head     = track[3:0];
      bytes    = '0;
      bytes[0] = 8'((addr % CHS_SECTORS) + 48'd1);
      bytes[1] = cyl[7:0];
      bytes[2] = cyl[15:8];
      sel      = DEVSEL_CHS;
      cmd      = r.direction ? CMD_WRITE : CMD_READ;
    end
    sel = sel | {3'b000, slave, head};
    push_write(ch, REG_CONTROL, CTRL_BASE, 1'b0);
    push_write(ch, REG_DEVSEL, sel, 1'b0);
    if (ext) begin
      push_high_write(ch, REG_COUNT1, 8'h00);
      push_high_write(ch, REG_LBA3, bytes[3]);
      push_high_write(ch, REG_LBA4, bytes[4]);
      push_high_write(ch, REG_LBA5, bytes[5]);
    end
    push_write(ch, REG_COUNT0, r.sector_count, 1'b0);
    push_write(ch, REG_LBA0, bytes[0], 1'b0);
    push_write(ch, REG_LBA1, bytes[1], 1'b0);
    push_write(ch, REG_LBA2, bytes[2], 1'b0);
    push_write(ch, REG_COMMAND, cmd, 1'b1);
  endfunction

  function automatic req_t make_request(input logic dir, input logic [1:0] slot,
                                        input logic [47:0] addr, input logic [7:0] count);
    req_t r;
    r.direction     = dir;
    r.device_slot   = slot;
    r.block_address = addr;
    r.sector_count  = count;
    return r;
  endfunction

  function automatic logic [47:0] rand_block_address();
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    case ($urandom_range(0, 4))
      0: return wide[47:0];
      1: return {20'h0, wide[27:0]};
      2: return LBA48_START - 48'($urandom_range(1, 64));
      3: return LBA48_START + 48'($urandom_range(0, 64));
      default: return 48'($urandom_range(0, 4095));
    endcase
  endfunction

  // Predict at the accepting edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) predict_taskfile_writes(in_data);
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected word: expected none, got %h", $time, out_data);
        mismatch_count++;
      end else begin
        want = pending_writes.pop_front();
        if (out_data.channel !== want.channel) begin
          $display("%0t: channel: expected %0h, got %0h", $time, want.channel,
                   out_data.channel);
          mismatch_count++;
        end
        if (out_data.register_index !== want.register_index) begin
          $display("%0t: register_index: expected %0h, got %0h", $time,
                   want.register_index, out_data.register_index);
          mismatch_count++;
        end
        if (out_data.write_data !== want.write_data) begin
          $display("%0t: write_data: expected %0h, got %0h", $time, want.write_data,
                   out_data.write_data);
          mismatch_count++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last: expected %0h, got %0h", $time, want.last, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : ready_driver
    int run_len;
    int stall_len;
    wait (rst == 1'b0);
    forever begin
      run_len   = $urandom_range(1, 12);
      stall_len = pick_gap();
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Valid stays high after acceptance so a zero gap keeps the stream going
  task automatic send_request(input req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    // let the predictor record the word accepted at this edge
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [3:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_CHANNEL: chan_map = val;
      CFG_SLAVE:   slave_map = val;
      CFG_LBA28:   lba_map = val;
      default: ;  // spare index: drop
    endcase
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] ch, input logic [3:0] slv,
                            input logic [3:0] lba);
    write_register(CFG_CHANNEL, ch);
    write_register(CFG_SLAVE, slv);
    write_register(CFG_LBA28, lba);
  endtask

  task automatic test_reset_defaults();
    send_request(make_request(1'b0, 2'd0, 48'd0, 8'h00));
    send_request(make_request(1'b1, 2'd1, 48'd62, 8'h01));
    send_request(make_request(1'b0, 2'd2, 48'd63, 8'h80));
    send_request(make_request(1'b1, 2'd3, 48'd1008, 8'hFF));
    wait_for_drain();
  endtask

  task automatic test_address_modes();
    set_config(4'b0101, 4'b0011, 4'b1010);
    // cylinder wraps past 16 bits at the top of the 28-bit range
    send_request(make_request(1'b1, 2'd0, 48'h0FFF_FFFF, 8'h10));
    send_request(make_request(1'b0, 2'd1, 48'h0FFF_FFFF, 8'h20));
    send_request(make_request(1'b0, 2'd2, LBA48_START, 8'h01));
    send_request(make_request(1'b1, 2'd3, LBA48_START, 8'hFE));
    send_request(make_request(1'b1, 2'd0, 48'hFFFF_FFFF_FFFF, 8'hFF));
    send_request(make_request(1'b0, 2'd1, 48'hAAAA_AAAA_AAAA, 8'h55));
    send_request(make_request(1'b1, 2'd2, 48'h5555_5555_5555, 8'hAA));
    send_request(make_request(1'b0, 2'd3, 48'd0, 8'h00));
    send_request(make_request(1'b1, 2'd1, 48'h05A5_A5A5, 8'h00));
    wait_for_drain();
  endtask

  task automatic test_register_extremes();
    set_config(4'h0, 4'h0, 4'h0);
    write_register(CFG_SPARE, 4'hF);
    send_request(make_request(1'b0, 2'd3, 48'd4000, 8'h07));
    send_request(make_request(1'b1, 2'd1, 48'h0123_4567, 8'h08));
    wait_for_drain();
    set_config(4'hF, 4'hF, 4'hF);
    write_register(CFG_SPARE, 4'h0);
    send_request(make_request(1'b0, 2'd0, 48'h0ABC_DEF0, 8'h09));
    send_request(make_request(1'b1, 2'd2, 48'h8000_0000_0001, 8'h0A));
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    for (int seg = 0; seg < 4; seg++) begin
      set_config(4'($urandom()), 4'($urandom()), 4'($urandom()));
      write_register(CFG_SPARE, 4'($urandom()));
      quiet = (seg == 2);
      for (int i = 0; i < 40; i++) begin
        send_request(make_request(1'($urandom()), 2'($urandom_range(0, 3)),
                                  rand_block_address(), 8'($urandom_range(0, 255))));
        // hold off mid-segment until the queue empties
        if (i == 20) wait_for_drain();
      end
      wait_for_drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_address_modes();
    test_register_extremes();
    test_random_traffic();
    wait_for_drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
